/* hdl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg : shared constants and types of the bitmap page allocator
// Page map geometry, request and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int PAGE_W    = 12;
   localparam int COUNT_W   = 9;
   localparam int NUM_PAGES = 4096;
   localparam int MAX_RUN   = 256;
   localparam int WORD_W    = 64;
   localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int ADDR_W    = $clog2(MAP_WORDS);
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int RUN_W     = $clog2(MAX_RUN + 1);
   localparam int LEVELS    = BIT_W + 1;
   localparam int LVL_W     = $clog2(LEVELS);

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_RESERVE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_OOM   = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_MARK_RD,
      S_MARK_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       req_load;
      logic       scan_init;
      logic       scan;
      logic       range_load;
      logic       mark_rd;
      logic       mark_wr;
      logic       rsp_load;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic is_range;
      logic alloc_ok;
      logic range_over;
      logic count_zero;
      logic scan_hit;
      logic scan_miss;
      logic mark_last;
   } stat_type;

endpackage

/* hdl/bpa_if.sv */
// ----------------------------------------------------------------------------
// bpa_if : request and response channels of the page allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface bpa_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [bpa_pkg::PAGE_W-1:0]   start_page;
   logic [bpa_pkg::COUNT_W-1:0]  span;

   modport source (output valid, action, start_page, span, input ready);
   modport sink   (input valid, action, start_page, span, output ready);
endinterface

interface bpa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::PAGE_W-1:0]   first_page;
   logic [1:0]                   status;

   modport source (output valid, first_page, status, input ready);
   modport sink   (input valid, first_page, status, output ready);
endinterface

/* hdl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram : generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = bpa_pkg::WORD_W,
   parameter int DEPTH = bpa_pkg::MAP_WORDS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bpa_datapath.sv */
// ----------------------------------------------------------------------------
// bpa_datapath : page map, run search and range marking
// Holds the request, the used-page map, the word-per-cycle run search and
// the read-modify-write path that sets or clears a page range.
// ----------------------------------------------------------------------------
module bpa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_action,
   input  logic [bpa_pkg::PAGE_W-1:0]  req_start_page,
   input  logic [bpa_pkg::COUNT_W-1:0] req_span,
   output logic [bpa_pkg::PAGE_W-1:0]  rsp_first_page,
   output logic [1:0]                  rsp_status,
   input  bpa_pkg::cmd_type            cmd,
   output bpa_pkg::stat_type           stat
);

   localparam int PAGE_W  = bpa_pkg::PAGE_W;
   localparam int COUNT_W = bpa_pkg::COUNT_W;
   localparam int WORD_W  = bpa_pkg::WORD_W;
   localparam int ADDR_W  = bpa_pkg::ADDR_W;
   localparam int BIT_W   = bpa_pkg::BIT_W;
   localparam int RUN_W   = bpa_pkg::RUN_W;
   localparam int LEVELS  = bpa_pkg::LEVELS;
   localparam int LVL_W   = bpa_pkg::LVL_W;

   // request
   logic [1:0]          action_ff;
   logic [PAGE_W-1:0]   start_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PAGE_W:0]     range_end;

   // map storage
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic                      ram_wr_en;
   logic [WORD_W-1:0]         ram_wr_data;
   logic [WORD_W-1:0]         ram_q;
   logic [bpa_pkg::MAP_WORDS-1:0] row_valid_ff;
   logic                      rd_row_ok_ff;
   logic [WORD_W-1:0]         rd_word;

   // scan
   logic [ADDR_W:0]     issue_ff;
   logic                scan_rd;
   logic                pend_ff;
   logic [ADDR_W-1:0]   eval_ff;
   logic [RUN_W-1:0]    run_ff;
   logic [RUN_W-1:0]    run_next;
   logic [RUN_W:0]      run_sum;
   logic [RUN_W:0]      run_add;
   logic [WORD_W-1:0]   free_w;
   logic [WORD_W-1:0]   pre_free;
   logic [WORD_W-1:0]   carry_hit;
   logic [WORD_W-1:0]   lvl [LEVELS];
   logic [LVL_W-1:0]    win_k;
   logic [COUNT_W-1:0]  win_rest;
   logic [BIT_W-1:0]    win_sh;
   logic [WORD_W-1:0]   win_hit;
   logic [WORD_W-1:0]   hit_vec;
   logic                any_hit;
   logic [BIT_W-1:0]    hit_idx;
   logic [BIT_W-1:0]    top_used;
   logic [PAGE_W-1:0]   hit_page;
   logic [PAGE_W-1:0]   first_calc;

   // marking
   logic [PAGE_W-1:0]   lo_ff;
   logic [PAGE_W-1:0]   hi_ff;
   logic                set_ff;
   logic [ADDR_W-1:0]   mark_addr_ff;
   logic [BIT_W-1:0]    lo_b;
   logic [BIT_W-1:0]    hi_b;
   logic [WORD_W-1:0]   mark_mask;

   // result
   logic [PAGE_W-1:0]   res_first_ff;
   logic [PAGE_W-1:0]   rsp_first_ff;
   logic [1:0]          rsp_status_ff;

   // ---------------- request and decode ----------------
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         action_ff <= req_action;
         start_ff  <= req_start_page;
         count_ff  <= req_span;
      end
   end

   assign range_end = {1'b0, start_ff} + {{(PAGE_W + 1 - COUNT_W){1'b0}}, count_ff};

   // ---------------- map storage ----------------
   assign scan_rd     = cmd.scan && !issue_ff[ADDR_W];
   assign ram_rd_en   = scan_rd || cmd.mark_rd;
   assign ram_rd_addr = cmd.mark_rd ? mark_addr_ff : issue_ff[ADDR_W-1:0];
   assign ram_wr_en   = cmd.mark_wr;

   bpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (bpa_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (mark_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   // rows never written read as all used
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.mark_wr) begin
         row_valid_ff[mark_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         rd_row_ok_ff <= row_valid_ff[ram_rd_addr];
      end
   end

   assign rd_word = rd_row_ok_ff ? ram_q : {WORD_W{1'b1}};

   // ---------------- scan control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         issue_ff <= '0;
      end else if (cmd.scan_init) begin
         pend_ff  <= 1'b0;
         issue_ff <= '0;
      end else begin
         pend_ff <= scan_rd;
         if (scan_rd) begin
            issue_ff <= issue_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_rd) begin
         eval_ff <= issue_ff[ADDR_W-1:0];
      end
      if (cmd.scan_init) begin
         run_ff <= '0;
      end else if (cmd.scan && pend_ff && !any_hit) begin
         run_ff <= run_next;
      end
   end

   // ---------------- run search over one word ----------------
   always_comb begin
      free_w = ~rd_word;

      // run that began in earlier words and reaches the count here
      for (int b = 0; b < WORD_W; b++) begin
         pre_free[b]  = (rd_word & ({WORD_W{1'b1}} >> (WORD_W - 1 - b))) == '0;
         run_sum      = {1'b0, run_ff} + (RUN_W + 1)'(b + 1);
         carry_hit[b] = pre_free[b] && (run_sum >= {1'b0, count_ff});
      end

      // lvl[j][b]: pages b-2^j+1 .. b of this word all free
      lvl[0] = free_w;
      for (int j = 0; j < LEVELS - 1; j++) begin
         lvl[j+1] = lvl[j] & (lvl[j] << (1 << j));
      end

      // window of count pages = two overlapping power-of-two windows
      win_k = '0;
      for (int j = 0; j < LEVELS; j++) begin
         if (count_ff[j]) begin
            win_k = LVL_W'(j);
         end
      end
      win_rest = count_ff - (COUNT_W'(1) << win_k);
      win_sh   = win_rest[BIT_W-1:0];
      win_hit  = lvl[win_k] & (lvl[win_k] << win_sh);
      if (count_ff > COUNT_W'(WORD_W)) begin
         win_hit = '0;
      end

      hit_vec = carry_hit | win_hit;
      any_hit = |hit_vec;

      hit_idx = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (hit_vec[b]) begin
            hit_idx = BIT_W'(b);
         end
      end

      top_used = '0;
      for (int b = 0; b < WORD_W; b++) begin
         if (rd_word[b]) begin
            top_used = BIT_W'(b);
         end
      end

      // free run carried into the next word, held at the longest request
      run_add = {1'b0, run_ff} + (RUN_W + 1)'(WORD_W);
      if (pre_free[WORD_W-1]) begin
         run_next = (run_add > (RUN_W + 1)'(bpa_pkg::MAX_RUN)) ?
                    RUN_W'(bpa_pkg::MAX_RUN) : run_add[RUN_W-1:0];
      end else begin
         // free pages above the highest used one: 63 - top_used
         run_next = {{(RUN_W - BIT_W){1'b0}}, ~top_used};
      end

      hit_page   = {eval_ff, hit_idx};
      first_calc = hit_page + PAGE_W'(1) - {{(PAGE_W - COUNT_W){1'b0}}, count_ff};
   end

   // ---------------- range registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         res_first_ff <= '0;
      end else if (stat.scan_hit) begin
         res_first_ff <= first_calc;
      end

      if (cmd.range_load) begin
         lo_ff        <= start_ff;
         hi_ff        <= range_end[PAGE_W-1:0] - PAGE_W'(1);
         set_ff       <= action_ff == bpa_pkg::ACT_RESERVE;
         mark_addr_ff <= start_ff[PAGE_W-1:BIT_W];
      end else if (stat.scan_hit) begin
         lo_ff        <= first_calc;
         hi_ff        <= hit_page;
         set_ff       <= 1'b1;
         mark_addr_ff <= first_calc[PAGE_W-1:BIT_W];
      end else if (cmd.mark_wr) begin
         mark_addr_ff <= mark_addr_ff + 1'b1;
      end
   end

   // ---------------- read-modify-write of one word ----------------
   always_comb begin
      lo_b = (mark_addr_ff == lo_ff[PAGE_W-1:BIT_W]) ? lo_ff[BIT_W-1:0] : '0;
      hi_b = (mark_addr_ff == hi_ff[PAGE_W-1:BIT_W]) ? hi_ff[BIT_W-1:0] : '1;
      // ~hi_b is 63 - hi_b
      mark_mask   = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (~hi_b));
      ram_wr_data = set_ff ? (rd_word | mark_mask) : (rd_word & ~mark_mask);
   end

   // ---------------- status to controller ----------------
   always_comb begin
      stat            = '0;
      stat.is_alloc   = action_ff == bpa_pkg::ACT_ALLOC;
      stat.is_range   = (action_ff == bpa_pkg::ACT_RELEASE) ||
                        (action_ff == bpa_pkg::ACT_RESERVE);
      stat.alloc_ok   = (count_ff != '0) && (count_ff <= COUNT_W'(bpa_pkg::MAX_RUN));
      stat.range_over = range_end > (PAGE_W + 1)'(bpa_pkg::NUM_PAGES);
      stat.count_zero = count_ff == '0;
      stat.scan_hit   = cmd.scan && pend_ff && any_hit;
      stat.scan_miss  = cmd.scan && pend_ff && !any_hit &&
                        (eval_ff == ADDR_W'(bpa_pkg::MAP_WORDS - 1));
      stat.mark_last  = mark_addr_ff == hi_ff[PAGE_W-1:BIT_W];
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_first_ff  <= res_first_ff;
         rsp_status_ff <= cmd.code;
      end
   end

   assign rsp_first_page = rsp_first_ff;
   assign rsp_status     = rsp_status_ff;

   // ---------------- checks ----------------
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      stat.scan_hit |-> (first_calc <= hit_page))
      else $error("run start lies above its end page");

   a_mark_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_wr |-> ((mark_addr_ff >= lo_ff[PAGE_W-1:BIT_W]) &&
                       (mark_addr_ff <= hi_ff[PAGE_W-1:BIT_W])))
      else $error("map write outside the marked range");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      cmd.range_load |=> (hi_ff >= lo_ff))
      else $error("range end below its start");

endmodule

/* hdl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpa_ctrl : request sequencer of the page allocator
// Accepts a request, steers decode, scan and marking in the datapath and
// loads the response register.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpa_pkg::cmd_type  cmd,
   input  bpa_pkg::stat_type stat
);

   bpa_pkg::state_type  state_ff, state_in;
   bpa_pkg::status_type code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpa_pkg::S_IDLE;
         code_ff      <= bpa_pkg::ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_ready = 1'b0;

      case (state_ff)
         bpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = bpa_pkg::S_DECIDE;
            end
         end
         bpa_pkg::S_DECIDE: begin
            code_in  = bpa_pkg::ST_DONE;
            state_in = bpa_pkg::S_RESP;
            if (stat.is_alloc) begin
               if (stat.alloc_ok) begin
                  cmd.scan_init = 1'b1;
                  state_in      = bpa_pkg::S_SCAN;
               end else begin
                  code_in = bpa_pkg::ST_OOM;
               end
            end else if (stat.is_range) begin
               if (stat.range_over) begin
                  code_in = bpa_pkg::ST_RANGE;
               end else if (!stat.count_zero) begin
                  cmd.range_load = 1'b1;
                  state_in       = bpa_pkg::S_MARK_RD;
               end
            end
         end
         bpa_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit) begin
               code_in  = bpa_pkg::ST_DONE;
               state_in = bpa_pkg::S_MARK_RD;
            end else if (stat.scan_miss) begin
               code_in  = bpa_pkg::ST_OOM;
               state_in = bpa_pkg::S_RESP;
            end
         end
         bpa_pkg::S_MARK_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = bpa_pkg::S_MARK_WR;
         end
         bpa_pkg::S_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            state_in    = stat.mark_last ? bpa_pkg::S_RESP : bpa_pkg::S_MARK_RD;
         end
         bpa_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = bpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bpa_pkg::S_IDLE;
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- checks ----------------
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register loaded while still held");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == bpa_pkg::S_DECIDE))
      else $error("accepted request not decoded next cycle");

   a_rmw_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_MARK_WR) |-> ($past(state_ff) == bpa_pkg::S_MARK_RD))
      else $error("map write without a preceding read");

endmodule

/* hdl/bitmap_page_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit : first-fit contiguous page allocator
// One used bit per page over 4096 pages; allocate, release and reserve.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries one request: action (allocate / release / reserve),
//   start_page and span. It is accepted when valid and ready are high.
//   rsp_chan returns exactly one response per request: first_page of the
//   allocated run (zero otherwise) and a status (done, out of memory,
//   range beyond last page).
//   One request is worked at a time. Release / reserve decode the request,
//   then read and write back each map word touched (1 to 9 words) and
//   load the response. Allocate scans the map one 64-page word per
//   cycle from page 0, over at most all 64 words, then marks the found run.
//   The scan is bound by the single read port of the map RAM.
//   Reset marks every page used; it takes effect at once (per-word valid
//   flags, no clearing sweep) and drops any pending response.
//   The response sits in an output register: a stalled receiver does not
//   stop the next request being accepted and worked, only its response
//   load waits until the previous response is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   bpa_req_if.sink     req_chan,
   bpa_rsp_if.source   rsp_chan
);

   bpa_pkg::cmd_type  cmd;
   bpa_pkg::stat_type stat;

   // sequencer: handshakes and step order
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // map RAM, run search, range marking and response payload
   bpa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_chan.action),
      .req_start_page (req_chan.start_page),
      .req_span       (req_chan.span),
      .rsp_first_page (rsp_chan.first_page),
      .rsp_status     (rsp_chan.status),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

/* dv/tb_bitmap_page_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_unit : self-checking bench of the page allocator
// Drives allocate, release and reserve requests over the valid/ready request
// channel and keeps a shadow page map that predicts every response. Responses
// are checked in order, field by field, under random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_unit;

   localparam int PAGE_W    = bpa_pkg::PAGE_W;
   localparam int COUNT_W   = bpa_pkg::COUNT_W;
   localparam int NUM_PAGES = bpa_pkg::NUM_PAGES;
   localparam int MAX_RUN   = bpa_pkg::MAX_RUN;

   // action code the block must ignore (no member of action_type)
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   // slowest request is a full-map scan plus marking
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_REQS  = 1000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [PAGE_W-1:0]   first_page;
      bpa_pkg::status_type status;
   } page_result_type;

   typedef struct {
      int unsigned first;
      int unsigned count;
   } page_run_type;

   logic clock = 1'b0;
   logic reset;

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();

   bitmap_page_allocator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow of the used bitmap, one flag per page
   bit              page_used [NUM_PAGES];
   // responses owed by the block, oldest first
   page_result_type pending_results [$];
   // runs handed out by allocate and not yet given back
   page_run_type    live_runs [$];

   int unsigned  mismatch_count = 0;
   bit           no_gaps        = 1'b0;  // both sides run back to back
   int unsigned  hold_request   = 0;     // asks the response side to stall
   int unsigned  hold_left      = 0;
   int unsigned  stall_left     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly zero or short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Shadow allocator: first-fit scan from page 0, range set / clear.
   // Updates the shadow map and returns the response the block owes.
   function automatic page_result_type predict_page_request(logic [1:0] act,
                                                            logic [PAGE_W-1:0] start,
                                                            logic [COUNT_W-1:0] count);
      page_result_type res;
      int unsigned     run;
      int unsigned     p;
      int unsigned     found;
      res.first_page = '0;
      res.status     = bpa_pkg::ST_DONE;
      found          = 0;
      if (act == bpa_pkg::ACT_ALLOC) begin
         // zero pages or more than the longest run: out of memory
         res.status = bpa_pkg::ST_OOM;
         if (count != 0 && count <= MAX_RUN) begin
            run = 0;
            for (p = 0; p < NUM_PAGES; p++) begin
               if (page_used[p]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == count) begin
                     found      = p + 1 - 32'(count);
                     res.status = bpa_pkg::ST_DONE;
                     break;
                  end
               end
            end
            if (res.status == bpa_pkg::ST_DONE) begin
               res.first_page = found[PAGE_W-1:0];
               for (p = found; p < found + 32'(count); p++) page_used[p] = 1'b1;
               live_runs.push_back('{found, 32'(count)});
            end
         end
      end else if (act == bpa_pkg::ACT_RELEASE || act == bpa_pkg::ACT_RESERVE) begin
         // a range past the last page changes nothing
         if (int'(start) + int'(count) > NUM_PAGES) begin
            res.status = bpa_pkg::ST_RANGE;
         end else begin
            for (p = 32'(start); p < 32'(start) + 32'(count); p++)
               page_used[p] = (act == bpa_pkg::ACT_RESERVE);
         end
      end
      return res;
   endfunction

   // Offer one request after a random gap; returns at the accepting edge.
   // valid is left high so a back-to-back request never drops it.
   task automatic issue_request(input logic [1:0] act,
                                input int unsigned start,
                                input int unsigned count);
      int unsigned         gap;
      logic [PAGE_W-1:0]   start_bits;
      logic [COUNT_W-1:0]  count_bits;
      start_bits = PAGE_W'(start);
      count_bits = COUNT_W'(count);
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.start_page <= start_bits;
      req_bus.span       <= count_bits;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_page_request(act, start_bits, count_bits));
   endtask

   // Sender goes quiet until every owed response has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Random range that mostly fits below the last page.
   task automatic pick_range(output int unsigned start, output int unsigned count);
      count = $urandom_range(1, MAX_RUN);
      start = $urandom_range(0, NUM_PAGES - 1);
      if (start + count > NUM_PAGES && $urandom_range(0, 3) != 0)
         start = NUM_PAGES - count;
   endtask

   function automatic int unsigned pick_alloc_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 90) return $urandom_range(9, 64);
      if (r < 97) return $urandom_range(65, MAX_RUN);
      if (r < 98) return 0;
      return $urandom_range(MAX_RUN + 1, 511);
   endfunction

   // Response side: long hold when asked, else random stalls.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (no_gaps) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Response checker: every accepted response against the oldest owed one.
   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response: first_page=%0d status=%0d",
                        rsp_bus.first_page, rsp_bus.status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.first_page !== want.first_page || rsp_bus.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch: first_page exp %0d got %0d, status exp %0d got %0d",
                           want.first_page, rsp_bus.first_page, want.status, rsp_bus.status);
            end
         end
      end
   end

   // After reset every page is used: any allocate is out of memory,
   // as are zero pages, one past the longest run and an all-ones count.
   task automatic test_all_used();
      issue_request(bpa_pkg::ACT_ALLOC, 0, 1);
      issue_request(bpa_pkg::ACT_ALLOC, 4095, 0);
      issue_request(bpa_pkg::ACT_ALLOC, 0, MAX_RUN + 1);
      issue_request(bpa_pkg::ACT_ALLOC, 0, 511);
      wait_drained();
   endtask

   // Range bounds: exact fit at both ends, one past the end, empty ranges
   // and the unknown action.
   task automatic test_range_limits();
      issue_request(bpa_pkg::ACT_RELEASE, 0, MAX_RUN);
      issue_request(bpa_pkg::ACT_RELEASE, NUM_PAGES - MAX_RUN, MAX_RUN);
      issue_request(bpa_pkg::ACT_RELEASE, 4095, 2);
      issue_request(bpa_pkg::ACT_RELEASE, NUM_PAGES - MAX_RUN + 1, MAX_RUN);
      issue_request(bpa_pkg::ACT_RESERVE, 4095, 511);
      issue_request(bpa_pkg::ACT_RELEASE, 4095, 0);
      issue_request(bpa_pkg::ACT_RESERVE, 0, 0);
      issue_request(ACT_UNKNOWN, 4095, 511);
      wait_drained();
   endtask

   // First fit: whole free blocks, a hole that spans a word boundary, a fit
   // into it, a request too long for what is left, then one that fits.
   task automatic test_first_fit();
      issue_request(bpa_pkg::ACT_ALLOC, 0, MAX_RUN);
      issue_request(bpa_pkg::ACT_ALLOC, 0, MAX_RUN);
      issue_request(bpa_pkg::ACT_ALLOC, 0, 1);
      issue_request(bpa_pkg::ACT_RELEASE, 60, 10);
      issue_request(bpa_pkg::ACT_ALLOC, 0, 8);
      issue_request(bpa_pkg::ACT_ALLOC, 0, 3);
      issue_request(bpa_pkg::ACT_ALLOC, 0, 2);
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   // back to back; the output register fills and the input stalls.
   task automatic test_response_hold();
      int unsigned start;
      int unsigned count;
      no_gaps      = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (10) begin
         pick_range(start, count);
         issue_request(bpa_pkg::ACT_RELEASE, start, count);
      end
      no_gaps = 1'b0;
      wait_drained();
   endtask

   // New requests arriving at an idle block after a full drain.
   task automatic test_sender_pause();
      repeat (3) issue_request(bpa_pkg::ACT_ALLOC, $urandom_range(0, 4095), pick_alloc_count());
      wait_drained();
      repeat (3) issue_request(bpa_pkg::ACT_ALLOC, $urandom_range(0, 4095), pick_alloc_count());
      wait_drained();
   endtask

   // Mostly well-formed traffic: allocations, returns of live runs and a
   // replay-like mix of range releases and reserves; the rest is noise.
   task automatic test_random_mix();
      int unsigned  n;
      int unsigned  r;
      int unsigned  idx;
      int unsigned  start;
      int unsigned  count;
      page_run_type run;
      logic [1:0]   act;
      for (n = 0; n < RANDOM_REQS; n++) begin
         // back-to-back stretch, then a drained pause, every 250 requests
         if (n % 250 == 100) no_gaps = 1'b1;
         if (n % 250 == 150) no_gaps = 1'b0;
         if (n % 250 == 200) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 35) begin
            issue_request(bpa_pkg::ACT_ALLOC, $urandom_range(0, 4095), pick_alloc_count());
         end else if (r < 60 && live_runs.size() != 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            issue_request(bpa_pkg::ACT_RELEASE, run.first, run.count);
         end else if (r < 85) begin
            pick_range(start, count);
            act = (r < 75) ? bpa_pkg::ACT_RELEASE : bpa_pkg::ACT_RESERVE;
            issue_request(act, start, count);
         end else begin
            act = $urandom_range(0, 1) ? bpa_pkg::ACT_RELEASE : bpa_pkg::ACT_RESERVE;
            case ($urandom_range(0, 2))
               0: begin
                  issue_request(ACT_UNKNOWN, $urandom_range(0, 4095), $urandom_range(0, 511));
               end
               1: begin
                  // guaranteed to cross the last page
                  count = $urandom_range(2, 511);
                  issue_request(act, $urandom_range(NUM_PAGES + 1 - count, 4095), count);
               end
               default: begin
                  issue_request(act, $urandom_range(0, 4095), 0);
               end
            endcase
         end
      end
      no_gaps = 1'b0;
      wait_drained();
   endtask

   // Main sequence: one reset, then the tests in turn.
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = bpa_pkg::ACT_ALLOC;
      req_bus.start_page = '0;
      req_bus.span       = '0;
      rsp_bus.ready      = 1'b0;
      foreach (page_used[i]) page_used[i] = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_all_used();
      test_range_limits();
      test_first_fit();
      test_response_hold();
      test_sender_pause();
      test_random_mix();

      // let any stray response show up before judging
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
